// ===== hw/rtl/daiba_pkg.sv =====
// ----------------------------------------------------------------------------
// daiba_pkg
// Shared types, constants and helpers for the dual-converter boxcar
// accumulator.
// ----------------------------------------------------------------------------
package daiba_pkg;

    // Frame length in sample slots (valid range 2..1024)
    localparam int FRAME_LEN = 32;
    localparam int SLOT_W    = $clog2(FRAME_LEN);
    localparam int CNT_W     = SLOT_W + 1;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int CHAN_W   = 5;
    localparam int LEVEL_W  = 2;
    localparam int IDX_W    = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [IDX_W-1:0] {
        REG_A_FIRST  = 2'd0,
        REG_A_SECOND = 2'd1,
        REG_B_FIRST  = 2'd2,
        REG_B_SECOND = 2'd3
    } reg_idx_t;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_IDLE   = 2'd0,
        LVL_FIRST  = 2'd1,
        LVL_ALL    = 2'd2,
        LVL_UNUSED = 2'd3
    } level_t;

    // Per-word control broadcast from the sequencer to both lanes
    typedef struct packed {
        logic tick;          // accepted sample word
        logic add_second;    // odd slot: add into second sum
        logic dump_first;    // clear first sum
        logic latch_first;   // copy first sum to its total
        logic dump_second;   // clear second sum
        logic latch_second;  // copy second sum to its total
    } lane_ctrl_t;

    typedef struct packed {
        logic [SUM_W-1:0] second;
        logic [SUM_W-1:0] first;
    } lane_totals_t;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]    acc,
        input logic [SAMPLE_W-1:0] v
    );
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, v};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/daiba_lane.sv =====
// ----------------------------------------------------------------------------
// daiba_lane
// One converter lane: even/odd running sums with saturation and the latched
// frame totals.
// ----------------------------------------------------------------------------
module daiba_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  daiba_pkg::lane_ctrl_t        ctrl,
    input  logic [daiba_pkg::SAMPLE_W-1:0] sample,
    output daiba_pkg::lane_totals_t      totals_next
);
    import daiba_pkg::*;

    logic [SUM_W-1:0] sum_first_reg, sum_first_next;
    logic [SUM_W-1:0] sum_second_reg, sum_second_next;
    lane_totals_t     totals_reg;
    logic [SUM_W-1:0] first_upd;
    logic [SUM_W-1:0] second_upd;

    always_comb
    begin
        first_upd  = sum_first_reg;
        second_upd = sum_second_reg;
        if (ctrl.tick && !ctrl.add_second)
        begin
            first_upd = sat_add(sum_first_reg, sample);
        end
        if (ctrl.tick && ctrl.add_second)
        begin
            second_upd = sat_add(sum_second_reg, sample);
        end

        sum_first_next  = ctrl.dump_first  ? '0 : first_upd;
        sum_second_next = ctrl.dump_second ? '0 : second_upd;

        // Totals take the sum including this word's sample
        totals_next = totals_reg;
        if (ctrl.latch_first)
        begin
            totals_next.first = first_upd;
        end
        if (ctrl.latch_second)
        begin
            totals_next.second = second_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
            totals_reg     <= '0;
        end
        else
        begin
            sum_first_reg  <= sum_first_next;
            sum_second_reg <= sum_second_next;
            totals_reg     <= totals_next;
        end
    end

endmodule

// ===== hw/rtl/daiba_ctrl.sv =====
// ----------------------------------------------------------------------------
// daiba_ctrl
// Slot sequencer: channel registers, slot counter, channel toggle and the
// ready-level handshake.
// ----------------------------------------------------------------------------
module daiba_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [daiba_pkg::IDX_W-1:0]   cfg_index,
    input  logic [daiba_pkg::CHAN_W-1:0]  cfg_wdata,
    input  logic                          fire,
    input  logic                          ack,
    output daiba_pkg::lane_ctrl_t         ctrl,
    output logic [daiba_pkg::CHAN_W-1:0]  next_chan_a,
    output logic [daiba_pkg::CHAN_W-1:0]  next_chan_b,
    output daiba_pkg::level_t             level_next
);
    import daiba_pkg::*;

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] WRAP_SLOT = CNT_W'(FRAME_LEN);

    logic [CHAN_W-1:0] chan_a_first_reg, chan_a_second_reg;
    logic [CHAN_W-1:0] chan_b_first_reg, chan_b_second_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              toggle_reg, toggle_next;
    level_t            level_reg;
    logic [CNT_W-1:0]  slot_inc;

    always_comb
    begin
        ctrl        = '0;
        slot_next   = slot_reg;
        toggle_next = toggle_reg;
        level_next  = level_reg;
        slot_inc    = {1'b0, slot_reg} + CNT_W'(1);

        if (fire && ack)
        begin
            level_next = LVL_IDLE;
        end
        else if (fire)
        begin
            ctrl.tick       = 1'b1;
            ctrl.add_second = slot_reg[0];
            toggle_next     = !slot_reg[0];
            slot_next       = slot_inc[SLOT_W-1:0];
            if (slot_inc == LAST_SLOT)
            begin
                ctrl.dump_first  = 1'b1;
                ctrl.latch_first = (level_reg == LVL_IDLE);
                if (level_reg == LVL_IDLE)
                begin
                    level_next = LVL_FIRST;
                end
            end
            else if (slot_inc == WRAP_SLOT)
            begin
                slot_next         = '0;
                ctrl.dump_second  = 1'b1;
                ctrl.latch_second = (level_reg == LVL_FIRST);
                if (level_reg == LVL_FIRST)
                begin
                    level_next = LVL_ALL;
                end
            end
        end

        next_chan_a = toggle_next ? chan_a_second_reg : chan_a_first_reg;
        next_chan_b = toggle_next ? chan_b_second_reg : chan_b_first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_a_first_reg  <= CHAN_W'(0);
            chan_a_second_reg <= CHAN_W'(1);
            chan_b_first_reg  <= CHAN_W'(0);
            chan_b_second_reg <= CHAN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_A_FIRST:  chan_a_first_reg  <= cfg_wdata;
                REG_A_SECOND: chan_a_second_reg <= cfg_wdata;
                REG_B_FIRST:  chan_b_first_reg  <= cfg_wdata;
                REG_B_SECOND: chan_b_second_reg <= cfg_wdata;
                default:      chan_a_first_reg  <= chan_a_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            toggle_reg <= 1'b0;
            level_reg  <= LVL_IDLE;
        end
        else
        begin
            slot_reg   <= slot_next;
            toggle_reg <= toggle_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== hw/rtl/dual_adc_interleaved_boxcar_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// dual_adc_interleaved_boxcar_accumulator_top
// Two-lane integrate-and-dump accumulator for a pair of 12-bit converters.
//
//   Group    Dir  Width  Carries
//   in_*     in   24+1   sample word (samples) or acknowledge word (tuser)
//   out_*    out  80     channels, ready level and four frame totals
//   cfg_*    in   2+5    channel register writes
//
// One word is accepted per cycle unless stalled; each yields one result word
// in the output register on the following cycle. The lanes and sequencer
// update in the same cycle as the accept, so back-to-back words see no bubble.
// Reset clears all sums, totals, the slot counter and the ready level.
// A stalled output holds the result and in_tready drops until it is taken.
// ----------------------------------------------------------------------------
module dual_adc_interleaved_boxcar_accumulator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [daiba_pkg::IDX_W-1:0]       cfg_index,
    input  logic [daiba_pkg::CHAN_W-1:0]      cfg_wdata,
    input  logic                              in_tvalid,
    output logic                              in_tready,
    // sample_a[11:0], sample_b[23:12]
    input  logic [daiba_pkg::IN_DATA_W-1:0]   in_tdata,
    // req_type[0]
    input  logic                              in_tuser,
    output logic                              out_tvalid,
    input  logic                              out_tready,
    // next_chan_a[4:0], next_chan_b[9:5], ready_level[11:10],
    // total_a_first[27:12], total_a_second[43:28],
    // total_b_first[59:44], total_b_second[75:60], zero pad [79:76]
    output logic [daiba_pkg::OUT_DATA_W-1:0]  out_tdata
);
    import daiba_pkg::*;

    logic              fire;
    lane_ctrl_t        ctrl;
    lane_totals_t      totals_a, totals_b;
    logic [CHAN_W-1:0] next_chan_a, next_chan_b;
    level_t            level_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign in_tready = !out_valid_reg || out_tready;
    assign fire      = in_tvalid && in_tready;

    daiba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .ack         (in_tuser),
        .ctrl        (ctrl),
        .next_chan_a (next_chan_a),
        .next_chan_b (next_chan_b),
        .level_next  (level_next)
    );

    daiba_lane u_lane_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (in_tdata[SAMPLE_W-1:0]),
        .totals_next (totals_a)
    );

    daiba_lane u_lane_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .totals_next (totals_b)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Merge both lanes and the sequencer into one result word
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {4'b0000,
                             totals_b.second, totals_b.first,
                             totals_a.second, totals_a.first,
                             level_next, next_chan_b, next_chan_a};
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/daiba_checker.sv =====
// ----------------------------------------------------------------------------
// daiba_checker
// Port-level checks for the boxcar accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module daiba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_tvalid,
    input logic                              in_tready,
    input logic                              in_tuser,
    input logic                              out_tvalid,
    input logic                              out_tready,
    input logic [daiba_pkg::OUT_DATA_W-1:0]  out_tdata
);
    import daiba_pkg::*;

    // Held result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid)
        else $error("result word dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_tvalid |-> in_tready)
        else $error("input stalled with empty output register");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready |=> out_tvalid)
        else $error("accepted word produced no result");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && in_tuser |=> out_tdata[11:10] == LVL_IDLE)
        else $error("acknowledge did not clear ready level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid |-> out_tdata[11:10] != LVL_UNUSED)
        else $error("ready level out of range");

endmodule

bind dual_adc_interleaved_boxcar_accumulator_top daiba_checker u_daiba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
);
